/* sv/csc_pkg.sv */
// csc_pkg: shared types, constants and coefficient math for the cardinal
// spline coefficients unit. No dependencies; imported by every module.
package csc_pkg;

  localparam int COORD_W  = 16;
  localparam int GAIN_W   = 16;
  localparam int TAN_W    = 34;
  localparam int COEF_W   = 40;
  localparam int FRAC_W   = 12;
  localparam int WIDE_W   = 42;
  localparam int NUM_AXES = 3;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic signed [WIDE_W-1:0] COEF_MAX = 42'sd549755813887;
  localparam logic signed [WIDE_W-1:0] COEF_MIN = -42'sd549755813888;

  // points seen in the current curve, also the kind of work a point causes
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_SECOND,
    KIND_MORE
  } kind_t;

  typedef struct packed {
    logic  in_acc;
    logic  b_adv;
    kind_t b_kind;
  } lane_ctrl_t;

  typedef struct packed {
    logic load;
    logic two;
    logic end1;
  } grp_t;

  typedef struct packed {
    logic [COEF_W-1:0] a;
    logic [COEF_W-1:0] b;
    logic [COEF_W-1:0] c;
    logic [COEF_W-1:0] d;
  } coef_t;

  typedef struct packed {
    coef_t seg1;
    coef_t seg2;
  } seg_pair_t;

  function automatic logic [COEF_W-1:0] sat_coef(input logic signed [WIDE_W-1:0] v);
    logic [COEF_W-1:0] r;
    if (v > COEF_MAX) begin
      r = COEF_MAX[COEF_W-1:0];
    end else if (v < COEF_MIN) begin
      r = COEF_MIN[COEF_W-1:0];
    end else begin
      r = v[COEF_W-1:0];
    end
    return r;
  endfunction

  function automatic coef_t coef_calc(input logic signed [COORD_W-1:0] p0,
                                      input logic signed [COORD_W-1:0] p1,
                                      input logic signed [TAN_W-1:0]   c0,
                                      input logic signed [TAN_W-1:0]   c1);
    logic signed [WIDE_W-1:0] d0;
    logic signed [WIDE_W-1:0] d1;
    logic signed [WIDE_W-1:0] t0;
    logic signed [WIDE_W-1:0] t1;
    logic signed [WIDE_W-1:0] dd;
    logic signed [WIDE_W-1:0] sa;
    logic signed [WIDE_W-1:0] sb;
    coef_t r;
    d0 = WIDE_W'(p0) <<< FRAC_W;
    d1 = WIDE_W'(p1) <<< FRAC_W;
    t0 = WIDE_W'(c0);
    t1 = WIDE_W'(c1);
    dd = d1 - d0;
    sa = t0 + t1 - (dd <<< 1);
    sb = (dd <<< 1) + dd - (t0 <<< 1) - t1;
    r.a = sat_coef(sa);
    r.b = sat_coef(sb);
    r.c = sat_coef(t0);
    r.d = sat_coef(d0);
    return r;
  endfunction

endpackage

/* sv/csc_lane.sv */
// csc_lane: one axis of the spline unit; keeps the last two points, forms the
// tangent products and the segment coefficients. Depends on csc_pkg.
module csc_lane import csc_pkg::*; (
  input  logic                      clk,
  input  lane_ctrl_t                ctrl,
  input  logic [GAIN_W-1:0]         gain,
  input  logic signed [COORD_W-1:0] coord,
  output seg_pair_t                 seg_o
);

  logic signed [COORD_W-1:0] rp0_r, rp1_r;
  logic signed [COORD_W-1:0] a_rp0_r, a_rp1_r, a_p_r;
  logic signed [TAN_W-1:0]   a_far_r, a_near_r;
  logic signed [TAN_W-1:0]   pend_r;
  seg_pair_t                 seg_r;

  logic signed [COORD_W:0]   diff_far, diff_near, gain_s;
  logic signed [TAN_W-1:0]   far_prod, near_prod;
  logic signed [TAN_W-1:0]   half_near;

  assign gain_s    = {1'b0, gain};
  assign diff_far  = coord - rp0_r;
  assign diff_near = coord - rp1_r;
  assign far_prod  = TAN_W'(gain_s) * TAN_W'(diff_far);
  assign near_prod = TAN_W'(gain_s) * TAN_W'(diff_near);
  assign half_near = a_near_r >>> 1;

  // point history and first stage: products for the new point
  always_ff @(posedge clk) begin
    if (ctrl.in_acc) begin
      rp0_r    <= rp1_r;
      rp1_r    <= coord;
      a_rp0_r  <= rp0_r;
      a_rp1_r  <= rp1_r;
      a_p_r    <= coord;
      a_far_r  <= far_prod;
      a_near_r <= near_prod;
    end
  end

  // second stage: coefficients and the tangent carried to the next segment
  always_ff @(posedge clk) begin
    if (ctrl.b_adv) begin
      case (ctrl.b_kind)
        KIND_SECOND: begin
          pend_r     <= half_near;
          seg_r.seg1 <= coef_calc(a_rp1_r, a_p_r, half_near, half_near);
        end
        KIND_MORE: begin
          pend_r     <= a_far_r;
          seg_r.seg1 <= coef_calc(a_rp0_r, a_rp1_r, pend_r, a_far_r);
          seg_r.seg2 <= coef_calc(a_rp1_r, a_p_r, a_far_r, half_near);
        end
        default: begin
        end
      endcase
    end
  end

  assign seg_o = seg_r;

endmodule

/* sv/csc_merge.sv */
// csc_merge: holds one point's group of lane results and sends them out one
// axis per beat through a registered output. Depends on csc_pkg.
module csc_merge import csc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  grp_t                     grp_in,
  input  seg_pair_t                seg_i [NUM_AXES],
  output logic                     grp_free,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_axis,
  output logic signed [COEF_W-1:0] out_coef_a,
  output logic signed [COEF_W-1:0] out_coef_b,
  output logic signed [COEF_W-1:0] out_coef_c,
  output logic signed [COEF_W-1:0] out_coef_d,
  output logic                     out_curve_end,
  output logic                     out_run_last
);

  logic       grp_valid_r, grp_two_r, grp_end1_r;
  logic       seg_r;
  logic [1:0] ax_r;
  logic       out_valid_r;
  logic [1:0] out_axis_r;
  coef_t      out_coef_r;
  logic       out_end_r, out_last_r;

  logic       take, emit, last;
  seg_pair_t  lane_sel;
  coef_t      coef_sel;

  assign take     = !out_valid_r || out_ready;
  assign emit     = grp_valid_r && take;
  assign last     = (ax_r == AXIS_Z) && (seg_r || !grp_two_r);
  assign grp_free = !grp_valid_r || (emit && last);

  always_comb begin
    case (ax_r)
      AXIS_X:  lane_sel = seg_i[0];
      AXIS_Y:  lane_sel = seg_i[1];
      AXIS_Z:  lane_sel = seg_i[2];
      default: lane_sel = seg_i[0];
    endcase
  end

  assign coef_sel = seg_r ? lane_sel.seg2 : lane_sel.seg1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      seg_r       <= 1'b0;
      ax_r        <= AXIS_X;
    end else begin
      if (take) begin
        out_valid_r <= grp_valid_r;
      end
      if (emit) begin
        if (last) begin
          seg_r <= 1'b0;
          ax_r  <= AXIS_X;
        end else if (ax_r == AXIS_Z) begin
          seg_r <= 1'b1;
          ax_r  <= AXIS_X;
        end else begin
          ax_r <= ax_r + 2'd1;
        end
      end
      if (grp_in.load) begin
        grp_valid_r <= 1'b1;
      end else if (emit && last) begin
        grp_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grp_in.load) begin
      grp_two_r  <= grp_in.two;
      grp_end1_r <= grp_in.end1;
    end
    if (emit) begin
      out_axis_r <= ax_r;
      out_coef_r <= coef_sel;
      out_end_r  <= seg_r | grp_end1_r;
      out_last_r <= last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_axis      = out_axis_r;
  assign out_coef_a    = out_coef_r.a;
  assign out_coef_b    = out_coef_r.b;
  assign out_coef_c    = out_coef_r.c;
  assign out_coef_d    = out_coef_r.d;
  assign out_curve_end = out_end_r;
  assign out_run_last  = out_last_r;

endmodule

/* sv/cardinal_spline_coefficients_unit.sv */
// cardinal_spline_coefficients_unit: top level; three axis lanes and the
// result merge. Depends on csc_pkg, csc_lane and csc_merge.
//
//   channel | direction | handshake              | beat
//   --------+-----------+------------------------+--------------------------------
//   cfg     | in        | cfg_wr_en              | tension_gain, Q4.12
//   in      | in        | in_valid / in_ready    | one control point, final flag
//   out     | out       | out_valid / out_ready  | one axis of one segment
//
// a point enters the product stage at acceptance and the coefficient stage when
// the merge's group is free; its results leave through the output register.
// a point that closes an inner segment gives 3 result beats, a final point with
// two segments 6: the single result port, one axis per beat, sets the rate.
// rst_n clears the point count, the pipe valids and the gain to 1.0.
// out_ready low holds the result register, then the group, then the input.
module cardinal_spline_coefficients_unit import csc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [GAIN_W-1:0]         cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_y,
  input  logic signed [COORD_W-1:0] in_coord_z,
  input  logic                      in_final_point,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_axis,
  output logic signed [COEF_W-1:0]  out_coef_a,
  output logic signed [COEF_W-1:0]  out_coef_b,
  output logic signed [COEF_W-1:0]  out_coef_c,
  output logic signed [COEF_W-1:0]  out_coef_d,
  output logic                      out_curve_end,
  output logic                      out_run_last
);

  logic [GAIN_W-1:0]         gain_r;
  kind_t                     seen_r;
  logic                      a_valid_r;
  kind_t                     a_kind_r;
  logic                      a_fin_r;

  logic                      in_acc, b_adv, grp_free;
  lane_ctrl_t                ctrl;
  grp_t                      grp;
  logic signed [COORD_W-1:0] coord [NUM_AXES];
  seg_pair_t                 seg [NUM_AXES];

  assign in_acc   = in_valid && in_ready;
  assign b_adv    = a_valid_r && grp_free;
  assign in_ready = !a_valid_r || b_adv;

  assign ctrl.in_acc = in_acc;
  assign ctrl.b_adv  = b_adv;
  assign ctrl.b_kind = a_kind_r;

  assign grp.load = b_adv && ((a_kind_r == KIND_MORE) ||
                              ((a_kind_r == KIND_SECOND) && a_fin_r));
  assign grp.two  = (a_kind_r == KIND_MORE) && a_fin_r;
  assign grp.end1 = (a_kind_r == KIND_SECOND);

  assign coord[0] = in_coord_x;
  assign coord[1] = in_coord_y;
  assign coord[2] = in_coord_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r    <= GAIN_RESET;
      seen_r    <= KIND_NONE;
      a_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        gain_r <= cfg_wr_data;
      end
      if (in_acc) begin
        a_valid_r <= 1'b1;
        if (in_final_point) begin
          seen_r <= KIND_NONE;
        end else begin
          case (seen_r)
            KIND_NONE:   seen_r <= KIND_SECOND;
            KIND_SECOND: seen_r <= KIND_MORE;
            default:     seen_r <= KIND_MORE;
          endcase
        end
      end else if (b_adv) begin
        a_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_kind_r <= seen_r;
      a_fin_r  <= in_final_point;
    end
  end

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    csc_lane u_lane (
      .clk   (clk),
      .ctrl  (ctrl),
      .gain  (gain_r),
      .coord (coord[g]),
      .seg_o (seg[g])
    );
  end

  csc_merge u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .grp_in        (grp),
    .seg_i         (seg),
    .grp_free      (grp_free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_axis      (out_axis),
    .out_coef_a    (out_coef_a),
    .out_coef_b    (out_coef_b),
    .out_coef_c    (out_coef_c),
    .out_coef_d    (out_coef_d),
    .out_curve_end (out_curve_end),
    .out_run_last  (out_run_last)
  );

endmodule

/* sv/csc_checker.sv */
// csc_checker: port-level checks on the spline unit's result channel, bound
// to the top level. Depends on csc_pkg and cardinal_spline_coefficients_unit.
module csc_checker import csc_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [1:0]                out_axis,
  input logic signed [COEF_W-1:0]  out_coef_a,
  input logic signed [COEF_W-1:0]  out_coef_b,
  input logic signed [COEF_W-1:0]  out_coef_c,
  input logic signed [COEF_W-1:0]  out_coef_d,
  input logic                      out_curve_end,
  input logic                      out_run_last
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_axis) &&
      $stable(out_coef_a) && $stable(out_coef_b) && $stable(out_coef_c) &&
      $stable(out_coef_d) && $stable(out_curve_end) && $stable(out_run_last))
    else $error("result beat changed while stalled");

  // a point's run always ends on the z axis
  a_last_on_z: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_last |-> out_axis == AXIS_Z)
    else $error("run ended on an axis other than z");

  // the axes of one segment follow each other with no gap
  a_x_then_y: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_axis == AXIS_X |=> out_valid && out_axis == AXIS_Y)
    else $error("y beat did not follow x beat");

  a_y_then_z: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_axis == AXIS_Y |=>
      out_valid && out_axis == AXIS_Z && out_curve_end == $past(out_curve_end))
    else $error("z beat did not follow y beat of the same segment");

  // a z beat that does not end its run is followed by the closing segment
  a_end_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_axis == AXIS_Z && !out_run_last |=>
      out_valid && out_axis == AXIS_X && out_curve_end)
    else $error("second segment of a final point missing");

endmodule

bind cardinal_spline_coefficients_unit csc_checker u_csc_checker (.*);

/* dv/cardinal_spline_coefficients_unit_tb.sv */
// cardinal_spline_coefficients_unit_tb: self-checking bench for the cardinal spline
// coefficients unit. Depends on csc_pkg and the RTL top cardinal_spline_coefficients_unit.
// A directed table is followed by random curves under four idle and stall mixes.
module cardinal_spline_coefficients_unit_tb;
  import csc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     NUM_DIR     = 24;
  localparam int     PHASE_ITEMS = 95;
  localparam int     SETTLE_CYC  = 12;
  localparam int     MAX_REPORTS = 20;
  localparam longint Q_HI        = 64'sd549755813887;
  localparam longint Q_LO        = -64'sd549755813888;

  typedef enum logic {ROW_POINT, ROW_GAIN} row_kind_t;

  typedef struct packed {
    row_kind_t                 kind;
    logic [GAIN_W-1:0]         gain;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      fin;
    int                        lit_n;  // -1: take the predictor, else number of results
    longint                    lit_a;
    longint                    lit_b;
    longint                    lit_c;
    longint                    lit_d;
  } stim_row_t;

  typedef struct {
    logic [1:0]               axis;
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
    logic signed [COEF_W-1:0] d;
    logic                     curve_end;
    logic                     run_last;
  } spline_coef_t;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_wr_en;
  logic [GAIN_W-1:0]         cfg_wr_data;
  logic                      in_valid;
  logic                      in_ready;
  logic signed [COORD_W-1:0] in_coord_x;
  logic signed [COORD_W-1:0] in_coord_y;
  logic signed [COORD_W-1:0] in_coord_z;
  logic                      in_final_point;
  logic                      out_valid;
  logic                      out_ready;
  logic [1:0]                out_axis;
  logic signed [COEF_W-1:0]  out_coef_a;
  logic signed [COEF_W-1:0]  out_coef_b;
  logic signed [COEF_W-1:0]  out_coef_c;
  logic signed [COEF_W-1:0]  out_coef_d;
  logic                      out_curve_end;
  logic                      out_run_last;

  cardinal_spline_coefficients_unit DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_coord_x    (in_coord_x),
    .in_coord_y    (in_coord_y),
    .in_coord_z    (in_coord_z),
    .in_final_point(in_final_point),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_axis      (out_axis),
    .out_coef_a    (out_coef_a),
    .out_coef_b    (out_coef_b),
    .out_coef_c    (out_coef_c),
    .out_coef_d    (out_coef_d),
    .out_curve_end (out_curve_end),
    .out_run_last  (out_run_last)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // spline state mirrored from the block
  logic [GAIN_W-1:0]         gain_q;
  logic signed [COORD_W-1:0] older_pt [3];
  logic signed [COORD_W-1:0] newer_pt [3];
  logic signed [TAN_W-1:0]   start_tan [3];
  kind_t                     pts_seen;

  spline_coef_t new_coefs [$];
  spline_coef_t coef_expected [$];

  int errors;
  int reports;
  int points_sent;
  int curves_closed;
  int beats_seen;
  int recv_stall_pct;
  int send_idle_pct;

  stim_row_t dir_rows [NUM_DIR] = '{
    '{ROW_POINT, 0,      0,      0,      0, 1,  0,          0,         0,          0,
      0},
    '{ROW_POINT, 0,      0,      0,      0, 0,  0,          0,         0,          0,
      0},
    '{ROW_POINT, 0,      1,      1,      1, 1,  3,      -4096,      6144,       2048,
      0},
    '{ROW_POINT, 0, -32768, -32768, -32768, 0,  0,          0,         0,          0,
      0},
    '{ROW_POINT, 0,  32767,  32767,  32767, 1,  3, -268431360, 402647040,  134215680,
      -134217728},
    '{ROW_POINT, 0,    100,   -200,    300, 0, -1,          0,         0,          0,
      0},
    '{ROW_POINT, 0,     -5,      7,  32767, 0, -1,          0,         0,          0,
      0},
    '{ROW_POINT, 0, -32768,  32767,      0, 1, -1,          0,         0,          0,
      0},
    '{ROW_GAIN,  65535,  0,      0,      0, 0, -1,          0,         0,          0,
      0},
    '{ROW_POINT, 0,  32767, -32768,      0, 0, -1,          0,         0,          0,
      0},
    '{ROW_POINT, 0, -32768,  32767,      1, 0, -1,          0,         0,          0,
      0},
    '{ROW_POINT, 0,  32767, -32768,     -1, 0, -1,          0,         0,          0,
      0},
    '{ROW_POINT, 0,      0,      0,      0, 1, -1,          0,         0,          0,
      0},
    '{ROW_GAIN,  0,      0,      0,      0, 0, -1,          0,         0,          0,
      0},
    '{ROW_POINT, 0,      5,      6,      7, 0, -1,          0,         0,          0,
      0},
    '{ROW_POINT, 0,      8,      9,     10, 1, -1,          0,         0,          0,
      0},
    '{ROW_POINT, 0,      0,      0,      0, 1,  0,          0,         0,          0,
      0},
    '{ROW_GAIN,  1,      0,      0,      0, 0, -1,          0,         0,          0,
      0},
    '{ROW_POINT, 0,      0,      0,      0, 0, -1,          0,         0,          0,
      0},
    '{ROW_POINT, 0,     -1,      3, -32768, 0, -1,          0,         0,          0,
      0},
    '{ROW_POINT, 0,      2,     -1,  32767, 1, -1,          0,         0,          0,
      0},
    '{ROW_GAIN,  4096,   0,      0,      0, 0, -1,          0,         0,          0,
      0},
    '{ROW_POINT, 0,      7,      7,      7, 0,  0,          0,         0,          0,
      0},
    '{ROW_POINT, 0,      7,      7,      7, 1,  3,          0,         0,          0,
      28672}
  };

  function automatic logic signed [COEF_W-1:0] sat_q12(input longint v);
    longint r;
    if (v > Q_HI) begin
      r = Q_HI;
    end else if (v < Q_LO) begin
      r = Q_LO;
    end else begin
      r = v;
    end
    return COEF_W'(r);
  endfunction

  function automatic longint full_tan(input longint diff);
    return longint'(gain_q) * diff;
  endfunction

  // arithmetic shift rounds the halved end tangent toward minus infinity
  function automatic longint half_tan(input longint diff);
    return full_tan(diff) >>> 1;
  endfunction

  function automatic spline_coef_t hermite_seg(input int ax, input longint p0, input longint p1,
                                               input longint c0, input longint c1,
                                               input logic at_end, input logic last);
    spline_coef_t s;
    longint d0;
    longint d1;
    d0 = p0 * 4096;
    d1 = p1 * 4096;
    s.axis      = 2'(ax);
    s.a         = sat_q12(2 * d0 - 2 * d1 + c0 + c1);
    s.b         = sat_q12(3 * d1 - 3 * d0 - 2 * c0 - c1);
    s.c         = sat_q12(c0);
    s.d         = sat_q12(d0);
    s.curve_end = at_end;
    s.run_last  = last;
    return s;
  endfunction

  function automatic void clear_curve();
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      older_pt[ax]  = '0;
      newer_pt[ax]  = '0;
      start_tan[ax] = '0;
    end
    pts_seen = KIND_NONE;
  endfunction

  // works out the coefficients one accepted point causes, into new_coefs
  function automatic void predict_point(input logic signed [COORD_W-1:0] px,
                                        input logic signed [COORD_W-1:0] py,
                                        input logic signed [COORD_W-1:0] pz,
                                        input logic fin);
    longint pt [3];
    longint tan_at [3];
    pt[0] = px;
    pt[1] = py;
    pt[2] = pz;
    new_coefs.delete();
    case (pts_seen)
      KIND_NONE: begin
        if (fin) begin
          clear_curve();
        end else begin
          for (int ax = 0; ax < NUM_AXES; ax++) newer_pt[ax] = COORD_W'(pt[ax]);
          pts_seen = KIND_SECOND;
        end
      end
      KIND_SECOND: begin
        for (int ax = 0; ax < NUM_AXES; ax++) begin
          start_tan[ax] = TAN_W'(half_tan(pt[ax] - longint'(newer_pt[ax])));
        end
        if (fin) begin
          for (int ax = 0; ax < NUM_AXES; ax++) begin
            new_coefs.insert(new_coefs.size(),
                             hermite_seg(ax, newer_pt[ax], pt[ax], start_tan[ax],
                                         half_tan(pt[ax] - longint'(newer_pt[ax])),
                                         1'b1, ax == AXIS_Z));
          end
          clear_curve();
        end else begin
          for (int ax = 0; ax < NUM_AXES; ax++) begin
            older_pt[ax] = newer_pt[ax];
            newer_pt[ax] = COORD_W'(pt[ax]);
          end
          pts_seen = KIND_MORE;
        end
      end
      default: begin
        // tangent at the newer kept point is now known
        for (int ax = 0; ax < NUM_AXES; ax++) begin
          tan_at[ax] = full_tan(pt[ax] - longint'(older_pt[ax]));
          new_coefs.insert(new_coefs.size(),
                           hermite_seg(ax, older_pt[ax], newer_pt[ax], start_tan[ax],
                                       tan_at[ax], 1'b0, !fin && ax == AXIS_Z));
        end
        if (fin) begin
          for (int ax = 0; ax < NUM_AXES; ax++) begin
            new_coefs.insert(new_coefs.size(),
                             hermite_seg(ax, newer_pt[ax], pt[ax], tan_at[ax],
                                         half_tan(pt[ax] - longint'(newer_pt[ax])),
                                         1'b1, ax == AXIS_Z));
          end
          clear_curve();
        end else begin
          for (int ax = 0; ax < NUM_AXES; ax++) begin
            older_pt[ax]  = newer_pt[ax];
            newer_pt[ax]  = COORD_W'(pt[ax]);
            start_tan[ax] = TAN_W'(tan_at[ax]);
          end
        end
      end
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    logic signed [COORD_W-1:0] v;
    case ($urandom_range(9))
      0:       v = -16'sd32768;
      1:       v = 16'sd32767;
      2:       v = '0;
      default: v = COORD_W'($urandom);
    endcase
    return v;
  endfunction

  function automatic stim_row_t make_point(input logic fin);
    stim_row_t r;
    r       = '0;
    r.kind  = ROW_POINT;
    r.x     = rand_coord();
    r.y     = rand_coord();
    r.z     = rand_coord();
    r.fin   = fin;
    r.lit_n = -1;
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_point(input stim_row_t r);
    spline_coef_t s;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_coord_x     <= r.x;
    in_coord_y     <= r.y;
    in_coord_z     <= r.z;
    in_final_point <= r.fin;
    do @(posedge clk); while (!in_ready);
    predict_point(r.x, r.y, r.z, r.fin);
    points_sent++;
    if (r.fin) curves_closed++;
    if (r.lit_n < 0) begin
      foreach (new_coefs[i]) coef_expected.insert(coef_expected.size(), new_coefs[i]);
    end else begin
      for (int ax = 0; ax < r.lit_n; ax++) begin
        s.axis      = 2'(ax);
        s.a         = COEF_W'(r.lit_a);
        s.b         = COEF_W'(r.lit_b);
        s.c         = COEF_W'(r.lit_c);
        s.d         = COEF_W'(r.lit_d);
        s.curve_end = 1'b1;
        s.run_last  = (ax == AXIS_Z);
        coef_expected.insert(coef_expected.size(), s);
      end
    end
    @(negedge clk);
  endtask

  // lets every expected beat out, then gives the pipe time to go quiet
  task automatic settle_pipe();
    in_valid <= 1'b0;
    while (coef_expected.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_gain(input logic [GAIN_W-1:0] g);
    settle_pipe();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= g;
    gain_q       = g;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    spline_coef_t e;
    if (rst_n && out_valid && out_ready) begin
      beats_seen++;
      if (coef_expected.size() == 0) begin
        errors++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("%0t: unexpected beat axis=%0d a=%0d b=%0d c=%0d d=%0d end=%0b last=%0b",
                   $realtime, out_axis, out_coef_a, out_coef_b, out_coef_c, out_coef_d,
                   out_curve_end, out_run_last);
        end
      end else begin
        e = coef_expected.pop_front();
        if (out_axis !== e.axis || out_coef_a !== e.a || out_coef_b !== e.b ||
            out_coef_c !== e.c || out_coef_d !== e.d || out_curve_end !== e.curve_end ||
            out_run_last !== e.run_last) begin
          errors++;
          if (reports < MAX_REPORTS) begin
            reports++;
            $display("%0t: mismatch exp axis=%0d a=%0d b=%0d c=%0d d=%0d end=%0b last=%0b",
                     $realtime, e.axis, e.a, e.b, e.c, e.d, e.curve_end, e.run_last);
            $display("%0t:          got axis=%0d a=%0d b=%0d c=%0d d=%0d end=%0b last=%0b",
                     $realtime, out_axis, out_coef_a, out_coef_b, out_coef_c, out_coef_d,
                     out_curve_end, out_run_last);
          end
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int send_idle [4];
    int recv_stall [4];
    int phase_pts;
    int len;
    logic [GAIN_W-1:0] g;
    send_idle      = '{0, 88, 0, 19};
    recv_stall     = '{0, 0, 88, 19};
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    in_coord_x     = '0;
    in_coord_y     = '0;
    in_coord_z     = '0;
    in_final_point = 1'b0;
    out_ready      = 1'b0;
    errors         = 0;
    reports        = 0;
    points_sent    = 0;
    curves_closed  = 0;
    beats_seen     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    gain_q         = GAIN_RESET;
    clear_curve();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_GAIN) begin
        write_gain(dir_rows[i].gain);
      end else begin
        send_point(dir_rows[i]);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      g = (ph == 1) ? 16'hFFFF : GAIN_W'($urandom);
      write_gain(g);
      send_idle_pct  = send_idle[ph];
      recv_stall_pct = recv_stall[ph];
      phase_pts      = 0;
      while (phase_pts < PHASE_ITEMS) begin
        if ($urandom_range(99) < 85) begin
          // well formed curve, occasionally a long one
          len = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
          for (int k = 0; k < len; k++) send_point(make_point(k == len - 1));
          phase_pts += len;
        end else begin
          send_point(make_point($urandom_range(1)));
          phase_pts++;
        end
      end
    end

    settle_pipe();
    recv_stall_pct = 0;
    repeat (SETTLE_CYC) @(negedge clk);
    $display("run covered %0d points in %0d closed curves, %0d coefficient beats checked",
             points_sent, curves_closed, beats_seen);
    $display("gains 0, 1, 1.0, max and random under four idle and stall mixes");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/csc_pkg.sv
sv/csc_lane.sv
sv/csc_merge.sv
sv/cardinal_spline_coefficients_unit.sv
sv/csc_checker.sv
dv/cardinal_spline_coefficients_unit_tb.sv
